// ===== hw/rtl/tfdc_pkg.sv =====
// Shared types, constants and the steering table of the track-follow drive controller.
package tfdc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LAUNCH_GEAR     = 3'd0,
    REG_BAND_SPLIT_GEAR = 3'd1,
    REG_LOW_RPM         = 3'd2,
    REG_MID_RPM         = 3'd3,
    REG_UPSHIFT_RPM     = 3'd4,
    REG_SPEED_OFFSET    = 3'd5,
    REG_SPEED_SLOPE     = 3'd6
  } tfdc_reg_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // |angle| > pi/2 in Q12
  localparam logic signed [14:0] WrongWayQ12 = 15'sd6434;
  localparam logic [8:0]         BrakeFull   = 9'd300;

  typedef struct packed {
    logic [2:0]         launch_gear;
    logic [2:0]         band_split_gear;
    logic [14:0]        low_rpm;
    logic [14:0]        mid_rpm;
    logic [14:0]        upshift_rpm;
    logic signed [13:0] speed_offset;
    logic [15:0]        speed_slope;
  } tfdc_cfg_t;

  typedef struct packed {
    logic signed [14:0] steer;
    logic [2:0]         gear;
    logic               accel;
    logic [8:0]         brake;
    logic               hold_update;
  } tfdc_decision_t;

  // round(8192 * (9 - idx) / 9), saturated to the 15-bit range
  function automatic logic signed [14:0] steer_from_index(input logic [4:0] idx);
    logic signed [14:0] s;
    case (idx)
      5'd0:    s = 15'sd8192;
      5'd1:    s = 15'sd7282;
      5'd2:    s = 15'sd6372;
      5'd3:    s = 15'sd5461;
      5'd4:    s = 15'sd4551;
      5'd5:    s = 15'sd3641;
      5'd6:    s = 15'sd2731;
      5'd7:    s = 15'sd1820;
      5'd8:    s = 15'sd910;
      5'd9:    s = 15'sd0;
      5'd10:   s = -15'sd910;
      5'd11:   s = -15'sd1820;
      5'd12:   s = -15'sd2731;
      5'd13:   s = -15'sd3641;
      5'd14:   s = -15'sd4551;
      5'd15:   s = -15'sd5461;
      5'd16:   s = -15'sd6372;
      5'd17:   s = -15'sd7282;
      5'd18:   s = -15'sd8192;
      5'd19:   s = -15'sd9102;
      5'd20:   s = -15'sd10012;
      5'd21:   s = -15'sd10923;
      5'd22:   s = -15'sd11833;
      5'd23:   s = -15'sd12743;
      5'd24:   s = -15'sd13653;
      5'd25:   s = -15'sd14564;
      5'd26:   s = -15'sd15474;
      default: s = -15'sd16384;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/tfdc_decide.sv =====
// Sweep-end decision logic: steering, gear selection and throttle/brake.
module tfdc_decide
  import tfdc_pkg::*;
(
  input  tfdc_cfg_t          cfg_i,
  input  logic [4:0]         best_index_i,
  input  logic signed [12:0] best_distance_i,
  input  logic signed [12:0] held_distance_i,
  input  logic signed [14:0] car_angle_i,
  input  logic signed [3:0]  current_gear_i,
  input  logic [14:0]        engine_rpm_i,
  input  logic signed [13:0] speed_forward_i,
  output tfdc_decision_t     decision_o
);

  logic               wrong_way;
  logic signed [12:0] held_eff;
  logic [2:0]         gear_low;
  logic               downshift;
  logic signed [14:0] speed_diff;
  logic signed [30:0] target_lhs;
  logic signed [29:0] target_rhs;
  logic               over;

  assign wrong_way = (car_angle_i >= WrongWayQ12) || (car_angle_i <= -WrongWayQ12);
  assign held_eff  = wrong_way ? held_distance_i : best_distance_i;

  // Only read when the gear is positive, so the low three bits carry it.
  assign gear_low  = current_gear_i[2:0];
  assign downshift = (!current_gear_i[3] && (gear_low > cfg_i.launch_gear) &&
                      (gear_low < cfg_i.band_split_gear) && (engine_rpm_i < cfg_i.low_rpm)) ||
                     (!current_gear_i[3] && (gear_low >= cfg_i.band_split_gear) &&
                      (engine_rpm_i <= cfg_i.mid_rpm));

  assign speed_diff = 15'(speed_forward_i) - 15'(cfg_i.speed_offset);
  assign target_lhs = 31'({speed_diff, 12'd0}) | {{4{speed_diff[14]}}, 27'd0};
  assign target_rhs = 30'($signed({1'b0, cfg_i.speed_slope})) * 30'(held_eff);
  assign over       = target_lhs > 31'(target_rhs);

  always_comb begin
    decision_o.hold_update = !wrong_way;
    decision_o.steer       = wrong_way ? car_angle_i : steer_from_index(best_index_i);
    if (current_gear_i <= 4'sd0) begin
      decision_o.gear = cfg_i.launch_gear;
    end else if (engine_rpm_i > cfg_i.upshift_rpm) begin
      decision_o.gear = gear_low + 3'd1;
    end else if (downshift) begin
      decision_o.gear = gear_low - 3'd1;
    end else begin
      decision_o.gear = gear_low;
    end
    decision_o.accel = !over;
    decision_o.brake = over ? BrakeFull : 9'd0;
  end

endmodule

// ===== hw/rtl/track_follow_drive_controller.sv =====
// Top level of the track-follow drive controller: reading stage, sweep argmax, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | in        | in_valid_i/in_stall_o| sensor_index, distance, sweep_last, car data
//   out     | out       | out_valid_o/out_stall_i | steer_cmd, gear_cmd, accel_cmd, brake_cmd
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One reading per cycle unless a stalled result holds a sweep-end reading; a result is
// registered in the result register from the reading stage when its last reading fires.
// Throughput is set by the single reading stage: argmax compare, steer table and one
// 17x13 multiply with compare sit between the reading register and the result register.
// Reset (asynchronous, active low) closes the sweep and loads register defaults.
// A stalled result holds only a sweep-end reading; other readings keep flowing.
module track_follow_drive_controller
  import tfdc_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = 19
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [4:0]               sensor_index_i,
  input  logic signed [12:0]       sensor_distance_i,
  input  logic                     sweep_last_i,
  input  logic signed [14:0]       car_angle_i,
  input  logic signed [3:0]        current_gear_in_i,
  input  logic [14:0]              engine_rpm_i,
  input  logic signed [13:0]       speed_forward_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [14:0]       steer_cmd_o,
  output logic [2:0]               gear_cmd_o,
  output logic                     accel_cmd_o,
  output logic [8:0]               brake_cmd_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  tfdc_cfg_t cfg_q;

  // reading stage
  logic               stg_valid_q;
  logic [4:0]         stg_index_q;
  logic signed [12:0] stg_dist_q;
  logic               stg_last_q;
  logic signed [14:0] stg_angle_q;
  logic signed [3:0]  stg_gear_q;
  logic [14:0]        stg_rpm_q;
  logic signed [13:0] stg_speed_q;

  // sweep state
  logic               sweep_open_q;
  logic [4:0]         best_index_q;
  logic signed [12:0] best_dist_q;
  logic signed [12:0] held_dist_q;

  // result register
  logic               out_valid_q;
  logic signed [14:0] steer_q;
  logic [2:0]         gear_q;
  logic               accel_q;
  logic [8:0]         brake_q;

  logic               blocked;
  logic               fire;
  logic               in_accept;
  logic               idx_ok;
  logic               take_reading;
  logic [4:0]         best_index_d;
  logic signed [12:0] best_dist_d;
  tfdc_decision_t     decision;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.launch_gear     <= 3'd1;
      cfg_q.band_split_gear <= 3'd4;
      cfg_q.low_rpm         <= 15'd1500;
      cfg_q.mid_rpm         <= 15'd4000;
      cfg_q.upshift_rpm     <= 15'd9500;
      cfg_q.speed_offset    <= 14'sd1280;
      cfg_q.speed_slope     <= 16'd4096;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LAUNCH_GEAR:     cfg_q.launch_gear     <= cfg_data_i[2:0];
        REG_BAND_SPLIT_GEAR: cfg_q.band_split_gear <= cfg_data_i[2:0];
        REG_LOW_RPM:         cfg_q.low_rpm         <= cfg_data_i[14:0];
        REG_MID_RPM:         cfg_q.mid_rpm         <= cfg_data_i[14:0];
        REG_UPSHIFT_RPM:     cfg_q.upshift_rpm     <= cfg_data_i[14:0];
        REG_SPEED_OFFSET:    cfg_q.speed_offset    <= $signed(cfg_data_i[13:0]);
        REG_SPEED_SLOPE:     cfg_q.speed_slope     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold a sweep-end reading while the result register is full and stalled.
  assign blocked    = stg_valid_q && stg_last_q && out_valid_q && out_stall_i;
  assign fire       = stg_valid_q && !blocked;
  assign in_stall_o = blocked;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (!blocked) begin
      stg_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stg_index_q <= sensor_index_i;
      stg_dist_q  <= sensor_distance_i;
      stg_last_q  <= sweep_last_i;
      stg_angle_q <= car_angle_i;
      stg_gear_q  <= current_gear_in_i;
      stg_rpm_q   <= engine_rpm_i;
      stg_speed_q <= speed_forward_i;
    end
  end

  // Running argmax; the first of equal distances stays.
  assign idx_ok       = 32'(stg_index_q) < NUM_SENSORS;
  assign take_reading = idx_ok && (!sweep_open_q || (stg_dist_q > best_dist_q));
  assign best_index_d = take_reading ? stg_index_q : best_index_q;
  assign best_dist_d  = take_reading ? stg_dist_q : best_dist_q;

  tfdc_decide u_decide (
    .cfg_i           (cfg_q),
    .best_index_i    (best_index_d),
    .best_distance_i (best_dist_d),
    .held_distance_i (held_dist_q),
    .car_angle_i     (stg_angle_q),
    .current_gear_i  (stg_gear_q),
    .engine_rpm_i    (stg_rpm_q),
    .speed_forward_i (stg_speed_q),
    .decision_o      (decision)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_open_q <= 1'b0;
      best_index_q <= '0;
      best_dist_q  <= '0;
      held_dist_q  <= '0;
    end else if (fire) begin
      if (stg_last_q) begin
        // close the sweep
        sweep_open_q <= 1'b0;
        best_index_q <= '0;
        best_dist_q  <= '0;
        if (decision.hold_update) begin
          held_dist_q <= best_dist_d;
        end
      end else begin
        sweep_open_q <= sweep_open_q || idx_ok;
        best_index_q <= best_index_d;
        best_dist_q  <= best_dist_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && stg_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && stg_last_q) begin
      steer_q <= decision.steer;
      gear_q  <= decision.gear;
      accel_q <= decision.accel;
      brake_q <= decision.brake;
    end
  end

  assign out_valid_o = out_valid_q;
  assign steer_cmd_o = steer_q;
  assign gear_cmd_o  = gear_q;
  assign accel_cmd_o = accel_q;
  assign brake_cmd_o = brake_q;

endmodule
